### sv/mcbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcbm_pkg;

   // clamp for the bank count exponent
   localparam logic [3:0] MAX_COUNT_LOG2   = 4'd9;
   localparam logic [3:0] RESET_COUNT_LOG2 = 4'd9;

   // low nibble that turns external ram on
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   // item kind
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register picked by address bits 14:13
   typedef enum logic [1:0] {
      SEL_RAM_CTRL = 2'd0,
      SEL_ROM_BANK = 2'd1,
      SEL_RAM_BANK = 2'd2,
      SEL_MODE     = 2'd3
   } reg_sel_type;

   typedef struct packed {
      logic        mode;
      logic [14:0] address;
      logic [7:0]  write_value;
   } req_type;

   typedef struct packed {
      logic       ram_enabled;
      logic [4:0] rom_mask_out;
      logic [8:0] lower_rom_bank;
      logic [8:0] upper_rom_bank;
      logic [8:0] rom_base;
      logic [3:0] ram_bank_out;
   } rsp_type;

endpackage

`default_nettype wire

### sv/multi_cart_bank_mapper_unit.sv
// the result is registered at the edge that accepts the item
// throughput: one item per cycle while results are taken; the update and mapping are
//   short combinational logic between the bank registers and the result register
// stalls: a held result stalls the input for as long as the result side stalls
// reset: synchronous, active high; unmapped, ram off, rom bank 1, bank count 2^9
`timescale 1ns / 1ps
`default_nettype none

module multi_cart_bank_mapper_unit
   import mcbm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_item,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_item,
   input  wire logic       csr_wr_en,
   input  wire logic [3:0] csr_wr_data
);

   // bank controller state
   logic       mapped_ff, mapped_in;
   logic       ram_en_ff, ram_en_in;
   logic       mux_ff, mux_in;
   logic       lock_ff, lock_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [6:0] ram_bank_ff, ram_bank_in;
   logic [4:0] rom_mask_ff, rom_mask_in;
   logic [1:0] ram_mask_ff, ram_mask_in;
   logic       bank_mode_ff, bank_mode_in;
   logic [3:0] count_log2_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic        req_accept;
   reg_sel_type sel;
   logic [6:0]  wval;
   logic [4:0]  rom_lm;
   logic [4:0]  rom_nl;
   logic [1:0]  ram_nl;

   logic [3:0] lg_clamped;
   logic [8:0] wrap_mask;
   logic [4:0] low, sel_low, sw_low;
   logic [1:0] mid, high, rlo, rhi, eff;
   logic [8:0] base_raw, upper_raw;
   logic [3:0] rbank;

   // hand-off: the result register frees up when taken
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assign sel    = reg_sel_type'(req_item.address[14:13]);
   assign wval   = req_item.write_value[6:0];
   assign rom_lm = rom_mask_ff & 5'h1E;
   assign rom_nl = (rom_bank_ff[4:0] & rom_lm) | (wval[4:0] & ~rom_lm);
   assign ram_nl = (ram_bank_ff[1:0] & ram_mask_ff) | (wval[1:0] & ~ram_mask_ff);

   // register update from a bus write
   always_comb begin
      mapped_in    = mapped_ff;
      ram_en_in    = ram_en_ff;
      mux_in       = mux_ff;
      lock_in      = lock_ff;
      rom_bank_in  = rom_bank_ff;
      ram_bank_in  = ram_bank_ff;
      rom_mask_in  = rom_mask_ff;
      ram_mask_in  = ram_mask_ff;
      bank_mode_in = bank_mode_ff;
      if (req_accept && req_item.mode == MODE_WRITE) begin
         case (sel)
            SEL_RAM_CTRL: begin
               ram_en_in = (wval[3:0] == RAM_ENABLE_KEY);
               if (!mapped_ff) begin
                  ram_mask_in = wval[5:4];
                  if (wval[6]) begin
                     mapped_in = 1'b1;
                  end
               end
            end
            SEL_ROM_BANK: begin
               rom_bank_in = {rom_bank_ff[6:5], rom_nl};
               if (!mapped_ff) begin
                  rom_bank_in = {wval[6:5], rom_nl};
               end
            end
            SEL_RAM_BANK: begin
               ram_bank_in = {ram_bank_ff[6:2], ram_nl};
               if (!mapped_ff) begin
                  ram_bank_in = {wval[6:2], ram_nl};
                  lock_in     = wval[6];
               end
            end
            SEL_MODE: begin
               if (!lock_ff) begin
                  bank_mode_in = wval[0];
               end
               if (!mapped_ff) begin
                  rom_mask_in = {wval[5:2], 1'b0};
                  mux_in      = wval[6];
               end
            end
            default: begin
               ram_en_in = ram_en_ff;
            end
         endcase
      end
   end

   // bank wrap mask from the configured count
   assign lg_clamped = (count_log2_ff > MAX_COUNT_LOG2) ? MAX_COUNT_LOG2 : count_log2_ff;
   assign wrap_mask  = 9'((10'd1 << lg_clamped) - 10'd1);

   // mapping from the updated registers
   assign low     = rom_bank_in[4:0];
   assign mid     = rom_bank_in[6:5];
   assign high    = ram_bank_in[5:4];
   assign rlo     = ram_bank_in[1:0];
   assign rhi     = ram_bank_in[3:2];
   assign sel_low = low & rom_mask_in;
   assign sw_low  = low | {4'd0, ((low & ~rom_mask_in) == 5'd0)};
   assign eff     = bank_mode_in ? rlo : (rlo & ram_mask_in);

   always_comb begin
      if (mux_in) begin
         base_raw  = {high, eff, sel_low};
         upper_raw = {high, rlo, sw_low};
         rbank     = {rhi, mid};
      end else begin
         base_raw  = {high, mid, sel_low};
         upper_raw = {high, mid, sw_low};
         rbank     = {rhi, eff};
      end
   end

   // result word; unmapped shows the top two banks
   always_comb begin
      rsp_in.ram_enabled  = ram_en_in;
      rsp_in.rom_mask_out = rom_mask_in;
      if (mapped_in) begin
         rsp_in.lower_rom_bank = base_raw & wrap_mask;
         rsp_in.upper_rom_bank = upper_raw & wrap_mask;
         rsp_in.rom_base       = base_raw;
         rsp_in.ram_bank_out   = rbank;
      end else begin
         rsp_in.lower_rom_bank = wrap_mask & 9'h1FE;
         rsp_in.upper_rom_bank = wrap_mask;
         rsp_in.rom_base       = wrap_mask & 9'h1FE;
         rsp_in.ram_bank_out   = 4'd0;
      end
   end

   // result valid: set on accept, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff     <= 1'b0;
         ram_en_ff     <= 1'b0;
         mux_ff        <= 1'b0;
         lock_ff       <= 1'b0;
         rom_bank_ff   <= 7'd1;
         ram_bank_ff   <= 7'd0;
         rom_mask_ff   <= 5'd0;
         ram_mask_ff   <= 2'd0;
         bank_mode_ff  <= 1'b0;
         count_log2_ff <= RESET_COUNT_LOG2;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mapped_ff    <= mapped_in;
         ram_en_ff    <= ram_en_in;
         mux_ff       <= mux_in;
         lock_ff      <= lock_in;
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         rom_mask_ff  <= rom_mask_in;
         ram_mask_ff  <= ram_mask_in;
         bank_mode_ff <= bank_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_log2_ff <= csr_wr_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTH
   // once mapped, stays mapped until reset
   a_mapped_sticky: assert property (@(posedge clock) disable iff (reset)
      mapped_ff |=> mapped_ff)
      else $error("mapped flag cleared without reset");

   // unmapped results never select a ram bank
   a_unmapped_ram_bank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !mapped_ff) |-> (rsp_ff.ram_bank_out == 4'd0))
      else $error("ram bank shown while unmapped");

   // a stalled result is held
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");

   // rom mask low bit is never set
   a_rom_mask_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.rom_mask_out[0] == 1'b0))
      else $error("rom mask bit zero set");
`endif

endmodule

`default_nettype wire
